@@ hdl/fbat_pkg.sv @@
// Package for the flow byte accounting table.
// Holds widths, command codes, the sequencer state type and the cell control struct.
// No dependencies.
package fbat_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int KEY_W         = 64;
  localparam int CNT_W         = 32;
  localparam int LEN_W         = 16;
  localparam int DROP_W        = 16;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY,
    ST_FLUSH
  } state_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic              match;
    logic              apply;
    logic              append;
    logic              shift;
    logic              inbound;
    logic [LEN_W-1:0]  len;
    logic [KEY_W-1:0]  key;
  } cell_ctrl_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {{(CNT_W + 1 - LEN_W){1'b0}}, b};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

@@ hdl/fbat_cell.sv @@
// One entry of the flow table chain: key, inbound and outbound byte counts.
// Depends on fbat_pkg (cell_ctrl_t, widths, sat_add).
module fbat_cell #(
  parameter int IDX    = 0,
  parameter int CNTR_W = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  fbat_pkg::cell_ctrl_t      ctrl,
  input  logic [CNTR_W-1:0]         count,
  input  logic [fbat_pkg::KEY_W-1:0] nbr_key,
  input  logic [fbat_pkg::CNT_W-1:0] nbr_in,
  input  logic [fbat_pkg::CNT_W-1:0] nbr_out,
  output logic [fbat_pkg::KEY_W-1:0] key,
  output logic [fbat_pkg::CNT_W-1:0] in_cnt,
  output logic [fbat_pkg::CNT_W-1:0] out_cnt,
  output logic                      hit
);
  import fbat_pkg::*;

  logic in_use;
  logic is_tail;

  assign in_use  = CNTR_W'(IDX) < count;
  assign is_tail = CNTR_W'(IDX) == count;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.match) begin
      hit <= in_use && (key == ctrl.key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key     <= nbr_key;
      in_cnt  <= nbr_in;
      out_cnt <= nbr_out;
    end else if (ctrl.apply) begin
      if (hit) begin
        if (ctrl.inbound) begin
          in_cnt <= sat_add(in_cnt, ctrl.len);
        end else begin
          out_cnt <= sat_add(out_cnt, ctrl.len);
        end
      end else if (ctrl.append && is_tail) begin
        key     <= ctrl.key;
        in_cnt  <= ctrl.inbound ? {{(CNT_W - LEN_W){1'b0}}, ctrl.len} : '0;
        out_cnt <= ctrl.inbound ? '0 : {{(CNT_W - LEN_W){1'b0}}, ctrl.len};
      end
    end
  end

endmodule

@@ hdl/flow_byte_accounting_table_top.sv @@
// Top level of the flow byte accounting table.
// Depends on fbat_pkg and fbat_cell.
//
// Per-flow byte accounting table built as a chain of TABLE_DEPTH cells, one
// flow entry per cell. An update request (cmd 0) looks up the key {ip_addr,
// remote_port, local_port} in every cell at once, then adds pkt_length to the
// matching entry's inbound or outbound count (saturating at 2^32-1). A new key
// is appended behind the last entry; when the table is full the update is
// dropped and an internal drop count counts it (saturating at 65535), shown on
// dropped_updates with each flush result. A flush request (cmd 1) streams all
// entries out in insertion order, marking the final one with last, and empties
// the table; the drop count survives a flush. A flush of an empty table gives
// one result with entry_valid 0 and last 1. An update passes three steps (request
// register, per-cell compare, per-cell add or append), the compare kept in the
// registered hit flags in each cell. A flush holds the block until every entry
// has left, longer while the output stalls, since entries leave from the head
// cell while the chain shifts one place per result. The output register lets a
// new request enter while the final result still waits. No clearing pass after
// reset is needed: only entries below the fill count are ever matched or emitted.
module flow_byte_accounting_table_top #(
  parameter int TABLE_DEPTH = fbat_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] ip_addr,
  input  logic [15:0] remote_port,
  input  logic [15:0] local_port,
  input  logic        inbound,
  input  logic [15:0] pkt_length,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_ip,
  output logic [15:0] out_remote_port,
  output logic [15:0] out_local_port,
  output logic [31:0] bytes_in,
  output logic [31:0] bytes_out,
  output logic        entry_valid,
  output logic        last,
  output logic [15:0] dropped_updates
);
  import fbat_pkg::*;

  localparam int CNTR_W = $clog2(TABLE_DEPTH + 1);

  state_t             state, state_next;
  logic [CNTR_W-1:0]  count, count_next;
  logic [DROP_W-1:0]  drop_count, drop_count_next;

  // latched request
  logic               req_inbound;
  logic [LEN_W-1:0]   req_len;
  logic [KEY_W-1:0]   req_key;

  cell_ctrl_t         ctrl;
  logic               out_take;
  logic               out_load;
  logic               out_empty;

  logic [KEY_W-1:0]   key_a   [TABLE_DEPTH];
  logic [CNT_W-1:0]   in_a    [TABLE_DEPTH];
  logic [CNT_W-1:0]   out_a   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit_v;
  logic               any_hit;

  assign in_ready = (state == ST_IDLE);
  assign out_take = !out_valid || out_ready;
  assign any_hit  = |hit_v;

  // Hold the request while the cells work on it.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_inbound <= inbound;
      req_len     <= pkt_length;
      req_key     <= {ip_addr, remote_port, local_port};
    end
  end

  // Chain of entry cells; each takes its upper neighbor's entry on a shift.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam int NB = (i + 1 < TABLE_DEPTH) ? i + 1 : i;
    fbat_cell #(
      .IDX    (i),
      .CNTR_W (CNTR_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .count   (count),
      .nbr_key (key_a[NB]),
      .nbr_in  (in_a[NB]),
      .nbr_out (out_a[NB]),
      .key     (key_a[i]),
      .in_cnt  (in_a[i]),
      .out_cnt (out_a[i]),
      .hit     (hit_v[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      drop_count <= '0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      drop_count <= drop_count_next;
    end
  end

  // Sequencer: next state, cell control and counters.
  always_comb begin
    state_next      = state;
    count_next      = count;
    drop_count_next = drop_count;
    out_load        = 1'b0;
    out_empty       = 1'b0;
    ctrl.match      = 1'b0;
    ctrl.apply      = 1'b0;
    ctrl.append     = 1'b0;
    ctrl.shift      = 1'b0;
    ctrl.inbound    = req_inbound;
    ctrl.len        = req_len;
    ctrl.key        = req_key;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (cmd == CMD_FLUSH) ? ST_FLUSH : ST_MATCH;
        end
      end
      ST_MATCH: begin
        ctrl.match = 1'b1;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        ctrl.apply  = 1'b1;
        ctrl.append = !any_hit && (count < CNTR_W'(TABLE_DEPTH));
        if (!any_hit) begin
          if (count < CNTR_W'(TABLE_DEPTH)) begin
            count_next = count + CNTR_W'(1);
          end else if (drop_count != {DROP_W{1'b1}}) begin
            drop_count_next = drop_count + DROP_W'(1);
          end
        end
        state_next = ST_IDLE;
      end
      ST_FLUSH: begin
        if (out_take) begin
          out_load = 1'b1;
          if (count == '0) begin
            out_empty  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            ctrl.shift = 1'b1;
            count_next = count - CNTR_W'(1);
            if (count == CNTR_W'(1)) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register: hold a result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      dropped_updates <= drop_count;
      if (out_empty) begin
        out_ip          <= '0;
        out_remote_port <= '0;
        out_local_port  <= '0;
        bytes_in        <= '0;
        bytes_out       <= '0;
        entry_valid     <= 1'b0;
        last            <= 1'b1;
      end else begin
        out_ip          <= key_a[0][63:32];
        out_remote_port <= key_a[0][31:16];
        out_local_port  <= key_a[0][15:0];
        bytes_in        <= in_a[0];
        bytes_out       <= out_a[0];
        entry_valid     <= 1'b1;
        last            <= (count == CNTR_W'(1));
      end
    end
  end

endmodule
